@@ sv/surface_normal_cross_product_macros.svh @@
// Assertion helpers used by the RTL.
`ifndef SURFACE_NORMAL_CROSS_PRODUCT_MACROS_SVH
`define SURFACE_NORMAL_CROSS_PRODUCT_MACROS_SVH

// Same-cycle implication, clocked on clk, off while in reset.
`define SNCP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off while in reset.
`define SNCP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/sncp_pkg.sv @@
`timescale 1ns / 1ps

package sncp_pkg;

  // Default limits of the line stores and window.
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_MAX_GRAD   = 8;

  // Field widths.
  localparam int COORD_W = 24;
  localparam int CODE_W  = 16;
  localparam int CFG_W   = 11;
  localparam int CFG_INDEX_W = 2;

  // Register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GRAD_STEP    = 2'd2;

  // Register reset values.
  localparam logic [10:0] RST_FRAME_WIDTH  = 11'd640;
  localparam logic [10:0] RST_FRAME_HEIGHT = 11'd480;
  localparam logic [3:0]  RST_GRAD_STEP    = 4'd2;

  // Code for a zero component: (0+1)/2 in Q0.16.
  localparam logic [CODE_W-1:0] MID_CODE = 16'd32768;

  typedef struct packed {
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } point_t;

  typedef struct packed {
    logic       last;
    logic       zero;
    logic [2:0] neg;
  } meta_t;

endpackage

@@ sv/surface_normal_cross_product.sv @@
`timescale 1ns / 1ps
// Surface normals from an organised point cloud, by cross product.
// s_axis: one point per beat in raster order; tdata carries x, y, z (signed
//   Q8.16), tuser marks the first pixel of a frame and restarts the counters.
// m_axis: one normal per complete window; tdata carries (n+1)/2 per component
//   in unsigned Q0.16, tuser is high for a valid normal (low with mid codes for
//   a zero cross product), tlast flags the normal of the frame's last pixel.
// cfg: write channel, always ready; index 0 frame_width, 1 frame_height,
//   2 grad_step. Write only while the block is idle.
// Throughput: one point per cycle while the output beat is not held, set by
//   the two-read-port line store that supplies both earlier rows of the window in one access.
// Path: the pixel completing its window passes the line store read,
//   differences, cross product, a six-step normaliser, squares, a 32-step
//   square root pipe and a 16-step divider pipe before its normal leaves.
// Stall: the whole pipe freezes while the output beat is held; s_axis_tready
//   follows the output register being free or taken.
// Reset: counters to pixel (0,0), registers to 640 x 480, step 2; the line
//   store is not cleared and holds no valid data until rows are written.
`include "surface_normal_cross_product_macros.svh"

module surface_normal_cross_product #(
  parameter int MAX_WIDTH  = sncp_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sncp_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_GRAD   = sncp_pkg::DEF_MAX_GRAD
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // point_x, point_y, point_z
  input  logic        s_axis_tuser,   // start_of_frame
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // normal_x, normal_y, normal_z
  output logic        m_axis_tuser,   // normal_valid
  output logic        m_axis_tlast,   // last_of_frame
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [sncp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sncp_pkg::CFG_W-1:0]       cfg_data
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int GW  = $clog2(MAX_GRAD);
  localparam int GDW = $clog2(MAX_GRAD + 1);
  localparam int MEM_DEPTH = MAX_GRAD * MAX_WIDTH;
  localparam int AW  = $clog2(MEM_DEPTH);
  localparam int NSQ = 32;   // square root steps
  localparam int NDV = 16;   // quotient bits

  // ---------------------------------------------------------------- config
  logic [10:0] frame_width;
  logic [10:0] frame_height;
  logic [3:0]  grad_step;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= sncp_pkg::RST_FRAME_WIDTH;
      frame_height <= sncp_pkg::RST_FRAME_HEIGHT;
      grad_step    <= sncp_pkg::RST_GRAD_STEP;
    end else if (cfg_valid) begin
      case (cfg_index)
        sncp_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        sncp_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        sncp_pkg::REG_GRAD_STEP:    grad_step    <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Clamped geometry
  logic [WW-1:0]  wc;
  logic [HW-1:0]  hc;
  logic [GDW-1:0] gc;
  logic [GDW-1:0] hh;
  logic [GDW-1:0] k1;
  logic [GDW-1:0] gm1;
  logic [GDW-1:0] k1m1;

  always_comb begin
    if (frame_width < 11'd2) wc = WW'(2);
    else if (32'(frame_width) > MAX_WIDTH) wc = WW'(MAX_WIDTH);
    else wc = WW'(frame_width);
    if (frame_height < 11'd2) hc = HW'(2);
    else if (32'(frame_height) > MAX_HEIGHT) hc = HW'(MAX_HEIGHT);
    else hc = HW'(frame_height);
    if (grad_step < 4'd1) gc = GDW'(1);
    else if (32'(grad_step) > MAX_GRAD) gc = GDW'(MAX_GRAD);
    else gc = GDW'(grad_step);
    hh   = gc >> 1;
    k1   = gc - hh;
    gm1  = gc - GDW'(1);
    k1m1 = k1 - GDW'(1);
  end

  // ---------------------------------------------------------------- handshake
  logic adv;
  logic acc;
  logic out_v;

  assign adv           = !out_v || m_axis_tready;
  assign s_axis_tready = adv;
  assign acc           = s_axis_tvalid && adv;

  // ---------------------------------------------------------------- counters
  logic [CW-1:0] col_cnt;
  logic [RW-1:0] row_cnt;
  logic [GW-1:0] row_slot;
  logic [CW-1:0] cur_col;
  logic [RW-1:0] cur_row;
  logic [GW-1:0] cur_slot;
  logic [CW-1:0] col_cnt_next;
  logic [RW-1:0] row_cnt_next;
  logic [GW-1:0] row_slot_next;
  logic          emit;
  logic          last_px;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr_b;
  logic [AW-1:0] rd_addr_c;
  logic [GW-1:0] slot_b;
  logic [GW-1:0] slot_c;

  always_comb begin
    cur_col  = s_axis_tuser ? '0 : col_cnt;
    cur_row  = s_axis_tuser ? '0 : row_cnt;
    cur_slot = s_axis_tuser ? '0 : row_slot;

    emit = (32'(cur_row) >= 32'(gc)) && (32'(cur_col) >= 32'(gc)) &&
           (32'(cur_row) < 32'(hc)) && (32'(cur_col) < 32'(wc));
    last_px = (32'(cur_row) == 32'(hc) - 1) && (32'(cur_col) == 32'(wc) - 1);

    // slots of the rows k1 and g above the current one
    if (32'(cur_slot) >= 32'(k1)) slot_b = GW'(32'(cur_slot) - 32'(k1));
    else slot_b = GW'(32'(cur_slot) + MAX_GRAD - 32'(k1));
    if (32'(cur_slot) >= 32'(gc)) slot_c = GW'(32'(cur_slot) - 32'(gc));
    else slot_c = GW'(32'(cur_slot) + MAX_GRAD - 32'(gc));

    wr_addr   = AW'(32'(cur_slot) * MAX_WIDTH + 32'(cur_col));
    rd_addr_b = AW'(32'(slot_b) * MAX_WIDTH + 32'(cur_col));
    rd_addr_c = AW'(32'(slot_c) * MAX_WIDTH + 32'(cur_col));

    if (32'(cur_col) + 1 >= 32'(wc)) begin
      col_cnt_next = '0;
      if (32'(cur_row) + 1 >= 32'(hc)) begin
        row_cnt_next  = '0;
        row_slot_next = '0;
      end else begin
        row_cnt_next  = cur_row + RW'(1);
        row_slot_next = (32'(cur_slot) + 1 == MAX_GRAD) ? '0 : cur_slot + GW'(1);
      end
    end else begin
      col_cnt_next  = cur_col + CW'(1);
      row_cnt_next  = cur_row;
      row_slot_next = cur_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt  <= '0;
      row_cnt  <= '0;
      row_slot <= '0;
    end else if (acc) begin
      col_cnt  <= col_cnt_next;
      row_cnt  <= row_cnt_next;
      row_slot <= row_slot_next;
    end
  end

  // ---------------------------------------------------------------- line store
  // Read-first: with g at its maximum the row g above shares the slot being
  // written, and the old entry is what the window needs.
  sncp_pkg::point_t row_store [MEM_DEPTH];
  sncp_pkg::point_t rd_b;
  sncp_pkg::point_t rd_c;

  always_ff @(posedge clk) begin
    if (acc) begin
      row_store[wr_addr] <= s_axis_tdata;
      rd_b <= row_store[rd_addr_b];
      rd_c <= row_store[rd_addr_c];
    end
  end

  // ---------------------------------------------------------------- stage 0
  logic             s0_valid;
  logic             s0_emit;
  logic             s0_last;
  sncp_pkg::point_t s0_p;

  always_ff @(posedge clk) begin
    if (rst) s0_valid <= 1'b0;
    else if (adv) s0_valid <= s_axis_tvalid;
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s0_emit <= emit;
      s0_last <= last_px;
      s0_p    <= s_axis_tdata;
    end
  end

  // Column tap lines: entry j holds the beat j+1 columns back in this row.
  sncp_pkg::point_t bline [MAX_GRAD];
  sncp_pkg::point_t cline [MAX_GRAD];
  sncp_pkg::point_t pline [MAX_GRAD];

  always_ff @(posedge clk) begin
    if (adv && s0_valid) begin
      bline[0] <= rd_b;
      cline[0] <= rd_c;
      pline[0] <= s0_p;
      for (int j = 1; j < MAX_GRAD; j++) begin
        bline[j] <= bline[j-1];
        cline[j] <= cline[j-1];
        pline[j] <= pline[j-1];
      end
    end
  end

  // ---------------------------------------------------------------- stage 1
  sncp_pkg::point_t ta, tc, td;
  logic signed [24:0] ux, uy, uz, vx, vy, vz;
  logic               s1_v;
  logic               s1_last;

  always_comb begin
    ta = bline[gm1[GW-1:0]];
    tc = cline[k1m1[GW-1:0]];
    td = pline[k1m1[GW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else if (adv) s1_v <= s0_valid && s0_emit;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_last <= s0_last;
      ux <= 25'(rd_b.x) - 25'(ta.x);
      uy <= 25'(rd_b.y) - 25'(ta.y);
      uz <= 25'(rd_b.z) - 25'(ta.z);
      vx <= 25'(td.x) - 25'(tc.x);
      vy <= 25'(td.y) - 25'(tc.y);
      vz <= 25'(td.z) - 25'(tc.z);
    end
  end

  // ---------------------------------------------------------------- stage 2
  logic signed [49:0] pr [6];
  logic               s2_v;
  logic               s2_last;

  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else if (adv) s2_v <= s1_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_last <= s1_last;
      pr[0] <= uy * vz;
      pr[1] <= uz * vy;
      pr[2] <= uz * vx;
      pr[3] <= ux * vz;
      pr[4] <= ux * vy;
      pr[5] <= uy * vx;
    end
  end

  // ---------------------------------------------------------------- stage 3
  logic signed [50:0] cr [3];
  logic [49:0]        mag3 [3];
  logic [2:0]         neg3;
  logic               s3_v;
  logic               s3_last;

  always_comb begin
    for (int i = 0; i < 3; i++) cr[i] = 51'(pr[2*i]) - 51'(pr[2*i+1]);
  end

  always_ff @(posedge clk) begin
    if (rst) s3_v <= 1'b0;
    else if (adv) s3_v <= s2_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_last <= s2_last;
      for (int i = 0; i < 3; i++) begin
        neg3[i] <= cr[i][50];
        mag3[i] <= cr[i][50] ? 50'(-cr[i]) : 50'(cr[i]);
      end
    end
  end

  // ---------------------------------------------------------------- normaliser
  // Left-justify all three magnitudes by the shift that brings the largest to
  // bit 63; bits [63:33] then put it in [2^30, 2^31).
  logic [49:0]     mx01;
  logic [49:0]     mx;
  logic            nv [7];
  sncp_pkg::meta_t nmeta [7];
  logic [63:0]     nw [7][3];
  logic [63:0]     nm [7];

  always_comb begin
    mx01 = (mag3[0] > mag3[1]) ? mag3[0] : mag3[1];
    mx   = (mx01 > mag3[2]) ? mx01 : mag3[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < 7; j++) nv[j] <= 1'b0;
    end else if (adv) begin
      nv[0] <= s3_v;
      for (int j = 1; j < 7; j++) nv[j] <= nv[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nmeta[0].last <= s3_last;
      nmeta[0].zero <= (mx == '0);
      nmeta[0].neg  <= neg3;
      nm[0] <= 64'(mx);
      for (int i = 0; i < 3; i++) nw[0][i] <= 64'(mag3[i]);
      for (int j = 1; j < 7; j++) begin
        nmeta[j] <= nmeta[j-1];
        if ((nm[j-1] >> (64 - (64 >> j))) == 64'd0) begin
          nm[j] <= nm[j-1] << (64 >> j);
          for (int i = 0; i < 3; i++) nw[j][i] <= nw[j-1][i] << (64 >> j);
        end else begin
          nm[j] <= nm[j-1];
          for (int i = 0; i < 3; i++) nw[j][i] <= nw[j-1][i];
        end
      end
    end
  end

  // ---------------------------------------------------------------- squares
  logic [30:0]     sqa [3];
  logic [61:0]     sqs [3];
  logic            sq_v;
  sncp_pkg::meta_t sq_meta;

  always_ff @(posedge clk) begin
    if (rst) sq_v <= 1'b0;
    else if (adv) sq_v <= nv[6];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_meta <= nmeta[6];
      for (int i = 0; i < 3; i++) begin
        sqa[i] <= nw[6][i][63:33];
        sqs[i] <= 62'(nw[6][i][63:33]) * 62'(nw[6][i][63:33]);
      end
    end
  end

  // ---------------------------------------------------------------- square root
  // One result bit a stage, trial bit walking down from 2^62.
  logic            rv [NSQ+1];
  sncp_pkg::meta_t rmeta [NSQ+1];
  logic [63:0]     rrem [NSQ+1];
  logic [63:0]     rres [NSQ+1];
  logic [30:0]     ra [NSQ+1][3];
  logic [63:0]     rrem_next [NSQ+1];
  logic [63:0]     rres_next [NSQ+1];
  logic [63:0]     rtry [NSQ+1];
  logic [63:0]     rbit [NSQ+1];

  always_comb begin
    rrem_next[0] = 64'(sqs[0]) + 64'(sqs[1]) + 64'(sqs[2]);
    rres_next[0] = '0;
    rtry[0] = '0;
    rbit[0] = '0;
    for (int s = 1; s <= NSQ; s++) begin
      rbit[s] = 64'd1 << (64 - 2 * s);
      rtry[s] = rres[s-1] + rbit[s];
      if (rrem[s-1] >= rtry[s]) begin
        rrem_next[s] = rrem[s-1] - rtry[s];
        rres_next[s] = (rres[s-1] >> 1) + rbit[s];
      end else begin
        rrem_next[s] = rrem[s-1];
        rres_next[s] = rres[s-1] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= NSQ; s++) rv[s] <= 1'b0;
    end else if (adv) begin
      rv[0] <= sq_v;
      for (int s = 1; s <= NSQ; s++) rv[s] <= rv[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rmeta[0] <= sq_meta;
      for (int i = 0; i < 3; i++) ra[0][i] <= sqa[i];
      for (int s = 0; s <= NSQ; s++) begin
        rrem[s] <= rrem_next[s];
        rres[s] <= rres_next[s];
      end
      for (int s = 1; s <= NSQ; s++) begin
        rmeta[s] <= rmeta[s-1];
        for (int i = 0; i < 3; i++) ra[s][i] <= ra[s-1][i];
      end
    end
  end

  // ---------------------------------------------------------------- divider
  // q = (a*2^16 + L) / (2L), one quotient bit a stage; q never exceeds 2^15.
  logic            dv [NDV+1];
  sncp_pkg::meta_t dmeta [NDV+1];
  logic [33:0]     dden [NDV+1];
  logic [48:0]     drem [NDV+1][3];
  logic [15:0]     dq [NDV+1][3];
  logic [31:0]     root;
  logic [48:0]     dsh [NDV+1];

  always_comb begin
    root   = rres[NSQ][31:0];
    dsh[0] = '0;
    for (int s = 1; s <= NDV; s++) dsh[s] = 49'(dden[s-1]) << (NDV - s);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= NDV; s++) dv[s] <= 1'b0;
    end else if (adv) begin
      dv[0] <= rv[NSQ];
      for (int s = 1; s <= NDV; s++) dv[s] <= dv[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dmeta[0] <= rmeta[NSQ];
      dden[0]  <= 34'(root) << 1;
      for (int i = 0; i < 3; i++) begin
        drem[0][i] <= (49'(ra[NSQ][i]) << 16) + 49'(root);
        dq[0][i]   <= '0;
      end
      for (int s = 1; s <= NDV; s++) begin
        dmeta[s] <= dmeta[s-1];
        dden[s]  <= dden[s-1];
        for (int i = 0; i < 3; i++) begin
          if (drem[s-1][i] >= dsh[s]) begin
            drem[s][i] <= drem[s-1][i] - dsh[s];
            dq[s][i]   <= dq[s-1][i] | (16'd1 << (NDV - s));
          end else begin
            drem[s][i] <= drem[s-1][i];
            dq[s][i]   <= dq[s-1][i];
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- output
  logic [16:0] enc [3];
  logic [15:0] code [3];
  logic [15:0] out_code [3];
  logic        out_nv;
  logic        out_last;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dmeta[NDV].neg[i]) enc[i] = 17'(sncp_pkg::MID_CODE) - 17'(dq[NDV][i]);
      else enc[i] = 17'(sncp_pkg::MID_CODE) + 17'(dq[NDV][i]);
      if (dmeta[NDV].zero) code[i] = sncp_pkg::MID_CODE;
      else if (enc[i][16]) code[i] = 16'hFFFF;
      else code[i] = enc[i][15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_v <= 1'b0;
    else if (adv) out_v <= dv[NDV];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_nv   <= !dmeta[NDV].zero;
      out_last <= dmeta[NDV].last;
      for (int i = 0; i < 3; i++) out_code[i] <= code[i];
    end
  end

  assign m_axis_tvalid = out_v;
  assign m_axis_tdata  = {out_code[2], out_code[1], out_code[0]};
  assign m_axis_tuser  = out_nv;
  assign m_axis_tlast  = out_last;

  // ---------------------------------------------------------------- checks
  `SNCP_ASSERT_IMP(a_zero_mid, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[15:0] == sncp_pkg::MID_CODE && m_axis_tdata[31:16] == sncp_pkg::MID_CODE && m_axis_tdata[47:32] == sncp_pkg::MID_CODE, "zero normal without mid codes")
  `SNCP_ASSERT_IMP(a_unit_not_mid, m_axis_tvalid && m_axis_tuser, m_axis_tdata[15:0] != sncp_pkg::MID_CODE || m_axis_tdata[31:16] != sncp_pkg::MID_CODE || m_axis_tdata[47:32] != sncp_pkg::MID_CODE, "valid normal of zero length")
  `SNCP_ASSERT_IMP(a_s1_from_adv, $rose(s1_v), $past(adv && s0_valid), "stage 1 loaded while frozen")
  `SNCP_ASSERT_NXT(a_s0_hold, s0_valid && !adv, s0_valid, "beat lost in stage 0 during stall")

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam int MAXW     = sncp_pkg::DEF_MAX_WIDTH;
  localparam int MAXH     = sncp_pkg::DEF_MAX_HEIGHT;
  localparam int MAXG     = sncp_pkg::DEF_MAX_GRAD;
  localparam int DRAIN    = 80;    // idle wait after the last expected normal, with margin
  localparam int HOLD_LEN = 300;   // long receiver hold-off
  localparam int WDOG_MAX = 4000;  // cycles without any accepted beat
  localparam int MIN_BEATS = 16;   // smallest number of beats in a phase

  typedef struct packed {
    logic [sncp_pkg::CODE_W-1:0] nx;
    logic [sncp_pkg::CODE_W-1:0] ny;
    logic [sncp_pkg::CODE_W-1:0] nz;
    logic                        vld;
    logic                        last;
  } normal_t;

  typedef struct {
    logic [sncp_pkg::COORD_W-1:0] x, y, z;
    bit                           sof;
    bit                           typed;   // expected normal written in below
    normal_t                      tres;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic m_axis_tuser;
  logic m_axis_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [sncp_pkg::CFG_INDEX_W-1:0] cfg_index = sncp_pkg::REG_FRAME_WIDTH;
  logic [sncp_pkg::CFG_W-1:0] cfg_data = '0;

  surface_normal_cross_product uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // ---- predictor state: line store, displaced entries, raster position
  sncp_pkg::point_t line_mem [0:MAXG*MAXW-1];
  sncp_pkg::point_t displaced [0:MAXG-1];
  int unsigned col_pos, row_pos;
  logic [10:0] width_reg  = sncp_pkg::RST_FRAME_WIDTH;
  logic [10:0] height_reg = sncp_pkg::RST_FRAME_HEIGHT;
  logic [3:0]  step_reg   = sncp_pkg::RST_GRAD_STEP;

  normal_t pending_normals [$];
  int      errors = 0;
  int      src_idle = 0;      // percent of cycles the sender idles
  int      sink_stall = 0;    // percent of cycles the receiver stalls
  int      hold_req = 0;      // bumped by the stimulus to ask for a hold-off
  int      hold_seen = 0;
  int      hold_left = 0;
  int      quiet_cycles = 0;

  function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // point k rows above the current one, at column cc
  function automatic sncp_pkg::point_t fetch_pt(int unsigned row, int unsigned k,
                                                int unsigned cc);
    if (k == MAXG) return displaced[cc % MAXG];
    return line_mem[((row - k) % MAXG) * MAXW + (cc % MAXW)];
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [sncp_pkg::CODE_W-1:0] encode_comp(longint unsigned a, bit neg,
                                                             longint unsigned len);
    longint unsigned q, e;
    q = (a * 65536 + len) / (2 * len);
    e = neg ? 32768 - q : 32768 + q;
    return e > 65535 ? 16'hFFFF : e[15:0];
  endfunction

  // advances the raster position; returns 1 when the pixel completes a window
  function automatic bit predict_normal(sncp_pkg::point_t p, bit sof, output normal_t r);
    int unsigned w, hgt, g, h, row, col, idx;
    sncp_pkg::point_t a, b, c, d;
    longint ux, uy, uz, vx, vy, vz;
    longint cr [3];
    longint unsigned mag [3];
    longint unsigned m, sum, len;
    bit produced;
    w = clampu(width_reg, 2, MAXW);
    hgt = clampu(height_reg, 2, MAXH);
    g = clampu(step_reg, 1, MAXG);
    h = g / 2;
    produced = 0;
    r = '0;
    if (sof) begin
      col_pos = 0;
      row_pos = 0;
    end
    row = row_pos;
    col = col_pos;
    idx = (row % MAXG) * MAXW + (col % MAXW);
    displaced[col % MAXG] = line_mem[idx];
    line_mem[idx] = p;
    if (row >= g && col >= g && row < hgt && col < w) begin
      a = fetch_pt(row, g - h, col - g);
      b = fetch_pt(row, g - h, col);
      c = fetch_pt(row, g, col - (g - h));
      d = fetch_pt(row, 0, col - (g - h));
      ux = longint'(b.x) - longint'(a.x);
      uy = longint'(b.y) - longint'(a.y);
      uz = longint'(b.z) - longint'(a.z);
      vx = longint'(d.x) - longint'(c.x);
      vy = longint'(d.y) - longint'(c.y);
      vz = longint'(d.z) - longint'(c.z);
      cr[0] = uy * vz - uz * vy;
      cr[1] = uz * vx - ux * vz;
      cr[2] = ux * vy - uy * vx;
      m = 0;
      for (int i = 0; i < 3; i++) begin
        mag[i] = cr[i] < 0 ? -cr[i] : cr[i];
        if (mag[i] > m) m = mag[i];
      end
      if (m == 0) begin
        r.nx = sncp_pkg::MID_CODE;
        r.ny = sncp_pkg::MID_CODE;
        r.nz = sncp_pkg::MID_CODE;
        r.vld = 1'b0;
      end else begin
        // bring the largest magnitude into [2^30, 2^31)
        while (m >= (64'd1 << 31)) begin
          m >>= 1;
          for (int i = 0; i < 3; i++) mag[i] >>= 1;
        end
        while (m < (64'd1 << 30)) begin
          m <<= 1;
          for (int i = 0; i < 3; i++) mag[i] <<= 1;
        end
        sum = 0;
        for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
        len = int_sqrt(sum);
        r.nx = encode_comp(mag[0], cr[0] < 0, len);
        r.ny = encode_comp(mag[1], cr[1] < 0, len);
        r.nz = encode_comp(mag[2], cr[2] < 0, len);
        r.vld = 1'b1;
      end
      r.last = (row == hgt - 1 && col == w - 1);
      produced = 1;
    end
    if (col + 1 >= w) begin
      col_pos = 0;
      row_pos = (row + 1 >= hgt) ? 0 : row + 1;
    end else begin
      col_pos = col + 1;
    end
    return produced;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // ---- input side: one point per call, idling at random before it
  task automatic send_point(sncp_pkg::point_t p, bit sof, bit typed = 0,
                            normal_t tres = '0);
    normal_t r;
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    if (predict_normal(p, sof, r))
      pending_normals.insert(pending_normals.size(), typed ? tres : r);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= p;
    s_axis_tuser  <= sof;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_normals.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // leaves cfg_valid high; the caller drops it after the last write
  task automatic write_reg(logic [sncp_pkg::CFG_INDEX_W-1:0] index,
                           logic [sncp_pkg::CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (index)
      sncp_pkg::REG_FRAME_WIDTH:  width_reg  = value;
      sncp_pkg::REG_FRAME_HEIGHT: height_reg = value;
      sncp_pkg::REG_GRAD_STEP:    step_reg   = value[3:0];
      default: ;
    endcase
  endtask

  task automatic set_frame(int w, int hgt, int g);
    write_reg(sncp_pkg::REG_FRAME_WIDTH, sncp_pkg::CFG_W'(w));
    write_reg(sncp_pkg::REG_FRAME_HEIGHT, sncp_pkg::CFG_W'(hgt));
    write_reg(sncp_pkg::REG_GRAD_STEP, sncp_pkg::CFG_W'(g));
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [sncp_pkg::COORD_W-1:0] rand_coord();
    case ($urandom_range(3))
      0: return 24'($urandom);
      1: return 24'($signed($urandom_range(511)) - 256);
      2: return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
      default: return 24'($urandom_range(15));
    endcase
  endfunction

  // one frame of random content; style picks noise, flat (zero cross) or a surface
  task automatic send_frame(int w, int hgt, bit sof_first);
    int style;
    sncp_pkg::point_t p;
    style = $urandom_range(3);
    for (int r = 0; r < hgt; r++) begin
      for (int c = 0; c < w; c++) begin
        case (style)
          0, 1: begin
            p.x = rand_coord(); p.y = rand_coord(); p.z = rand_coord();
          end
          2: begin
            p.x = 24'h012345; p.y = 24'hFEDCBA; p.z = 24'h000777;
          end
          default: begin
            p.x = 24'(c << 16);
            p.y = 24'(r << 16);
            p.z = 24'($signed($urandom_range(8191)) - 4096);
          end
        endcase
        // occasional stray start marker restarts the raster mid-frame
        send_point(p, (r == 0 && c == 0) ? sof_first : ($urandom_range(99) < 2));
      end
    end
  endtask

  // ---- output side: check each beat against the oldest expectation
  always @(posedge clk) begin
    normal_t want;
    if (m_axis_tvalid && m_axis_tready && !rst) begin
      if (pending_normals.size() == 0) begin
        report_mismatch("unexpected normal", m_axis_tdata, 0);
      end else begin
        want = pending_normals.pop_front();
        if (m_axis_tdata[15:0] !== want.nx)  report_mismatch("normal_x", m_axis_tdata[15:0], want.nx);
        if (m_axis_tdata[31:16] !== want.ny) report_mismatch("normal_y", m_axis_tdata[31:16], want.ny);
        if (m_axis_tdata[47:32] !== want.nz) report_mismatch("normal_z", m_axis_tdata[47:32], want.nz);
        if (m_axis_tuser !== want.vld)       report_mismatch("normal_valid", m_axis_tuser, want.vld);
        if (m_axis_tlast !== want.last)      report_mismatch("last_of_frame", m_axis_tlast, want.last);
      end
    end
  end

  // ---- receiver: random stalls, and a long hold-off counted here
  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall);
    end
  end

  // ---- watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_MAX) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // ---- stimulus
  dir_row_t dir_tab [18];
  int phase_w [12] = '{11, 6, 9, 5, 2, 7, 4, 0, 3, 12, 6, 7};
  int phase_h [12] = '{9, 5, 9, 5, 3, 3, 5, 5, 2, 2, 4, 7};
  int phase_g [12] = '{2, 3, 15, 4, 1, 5, 5, 0, 8, 1, 7, 6};

  initial begin
    normal_t mid;
    sncp_pkg::point_t p;
    int w, hgt, nframes;
    mid = '{nx: sncp_pkg::MID_CODE, ny: sncp_pkg::MID_CODE, nz: sncp_pkg::MID_CODE,
            vld: 1'b0, last: 1'b0};
    // flat frame: every window is a zero cross product
    for (int i = 0; i < 9; i++)
      dir_tab[i] = '{x: 0, y: 0, z: 0, sof: (i == 0), typed: (i % 3 != 0 && i > 3),
                     tres: mid};
    dir_tab[8].tres.last = 1'b1;
    // extremes of every coordinate and three other points, checked by the predictor
    dir_tab[9]  = '{24'h7FFFFF, 24'h000000, 24'h000000, 1, 0, '0};
    dir_tab[10] = '{24'h800000, 24'h7FFFFF, 24'h000000, 0, 0, '0};
    dir_tab[11] = '{24'h000000, 24'h800000, 24'h7FFFFF, 0, 0, '0};
    dir_tab[12] = '{24'h000000, 24'h000000, 24'h800000, 0, 0, '0};
    dir_tab[13] = '{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 0, 0, '0};
    dir_tab[14] = '{24'h800000, 24'h800000, 24'h800000, 0, 0, '0};
    dir_tab[15] = '{24'h123456, 24'h000000, 24'hFEDCBA, 0, 0, '0};
    dir_tab[16] = '{24'h000001, 24'h000001, 24'h000001, 0, 0, '0};
    dir_tab[17] = '{24'hFFFFFF, 24'h000000, 24'h000001, 0, 0, '0};
    for (int i = 0; i < MAXG * MAXW; i++) line_mem[i] = '0;
    for (int i = 0; i < MAXG; i++) displaced[i] = '0;
    col_pos = 0;
    row_pos = 0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: 3 x 3 frames, step 1
    set_frame(3, 3, 1);
    foreach (dir_tab[i]) begin
      p.x = dir_tab[i].x; p.y = dir_tab[i].y; p.z = dir_tab[i].z;
      send_point(p, dir_tab[i].sof, dir_tab[i].typed, dir_tab[i].tres);
    end
    wait_idle();

    // random phases; idling pattern rotates through the four modes
    foreach (phase_w[k]) begin
      case (k % 4)
        0: begin src_idle = 0;  sink_stall = 0;  end
        1: begin src_idle = 46; sink_stall = 0;  end
        2: begin src_idle = 0;  sink_stall = 46; end
        default: begin src_idle = 24; sink_stall = 24; end
      endcase
      set_frame(phase_w[k], phase_h[k], phase_g[k]);
      w = clampu(phase_w[k], 2, MAXW);
      hgt = clampu(phase_h[k], 2, MAXH);
      nframes = (w * hgt >= MIN_BEATS) ? 1 : (MIN_BEATS + w * hgt - 1) / (w * hgt);
      if (k == 0) begin
        // receiver holds off while the sender keeps offering: pipe fills up
        src_idle = 0;
        hold_req++;
      end
      for (int f = 0; f < nframes; f++)
        send_frame(w, hgt, (f == 0) ? 1'b1 : bit'($urandom_range(1)));
      wait_idle();
    end

    if (errors == 0 && pending_normals.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/sncp_pkg.sv
sv/surface_normal_cross_product.sv
test/tb_top.sv
